[hdl/fucs_pkg.sv]
// Shared types and constants of the framed serial command slave.
// Used by every module under hdl; depends on nothing else.
package fucs_pkg;

  // Frame layout: two head bytes, fourteen body bytes (command, length,
  // eight data bytes, a spare byte, checksum, two tail bytes).
  localparam logic [7:0] HEAD0_BYTE = 8'hAA;
  localparam logic [7:0] HEAD1_BYTE = 8'h55;
  localparam logic [7:0] TAIL0_BYTE = 8'hBB;
  localparam logic [7:0] TAIL1_BYTE = 8'h66;
  localparam logic [7:0] HEAD_SUM   = 8'hFF;  // the two head bytes added
  localparam logic [7:0] OK_CODE    = 8'h00;

  localparam int unsigned BODY_LEN   = 14;
  localparam int unsigned CNT_W      = $clog2(BODY_LEN);
  localparam logic [CNT_W-1:0] BODY_LAST = CNT_W'(BODY_LEN - 1);
  localparam logic [CNT_W-1:0] SUM_LAST  = CNT_W'(10);

  localparam logic [7:0] LEN_ACK      = 8'd1;
  localparam logic [7:0] LEN_WORD     = 8'd4;
  localparam logic [7:0] MIN_LEN_ONE  = 8'd4;
  localparam logic [7:0] MIN_LEN_TWO  = 8'd8;

  localparam logic [3:0] TX_LAST = 4'd15;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_SPEED = 2'd1;
  localparam logic [1:0] MODE_TIMED = 2'd2;

  localparam int unsigned NUM_CODES = 6;
  localparam logic [7:0] CODE_RST [NUM_CODES] = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6};
  localparam logic signed [31:0] DEFAULT_SPEED_RST = 32'sd0;
  localparam logic signed [31:0] DEFAULT_ANGLE_RST = 32'sd0;

  // Depth of the reply job queue between front and back.
  localparam int unsigned JQ_DEPTH = 2;
  localparam int unsigned JQ_PTR_W = $clog2(JQ_DEPTH);
  localparam int unsigned JQ_CNT_W = $clog2(JQ_DEPTH + 1);

  typedef enum logic [2:0] {
    CFG_CODE_SET_SPEED   = 3'd0,
    CFG_CODE_QUERY_SPEED = 3'd1,
    CFG_CODE_SPEED_TIME  = 3'd2,
    CFG_CODE_STOP        = 3'd3,
    CFG_CODE_SET_ANGLE   = 3'd4,
    CFG_CODE_QUERY_ANGLE = 3'd5,
    CFG_DEFAULT_SPEED    = 3'd6,
    CFG_DEFAULT_ANGLE    = 3'd7
  } cfg_idx_t;

  // One reply frame waiting to be serialized, with the target snapshot.
  typedef struct packed {
    logic [7:0]         cmd;
    logic               word_reply;
    logic [31:0]        word;
    logic [7:0]         csum;
    logic               notify;
    logic signed [31:0] speed;
    logic signed [31:0] duration;
    logic signed [31:0] angle;
    logic [1:0]         mode;
  } job_t;

endpackage

[hdl/fucs_rx_front.sv]
// Receive side: head hunting, body capture, frame checks, command decode,
// target registers and configuration registers. Depends on fucs_pkg.
module fucs_rx_front import fucs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  input  logic        q_full,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        job_push,
  output job_t        job
);

  typedef enum logic [2:0] {
    PH_HEAD0 = 3'b001,
    PH_HEAD1 = 3'b010,
    PH_BODY  = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    K_NONE, K_SET_SPEED, K_QUERY_SPEED, K_SPEED_TIME, K_STOP, K_SET_ANGLE, K_QUERY_ANGLE
  } kind_t;

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [7:0]         store_r [BODY_LEN];
  logic [7:0]         sum_r;
  logic [7:0]         code_r [NUM_CODES];
  logic signed [31:0] dflt_speed_r, dflt_speed_nxt;
  logic signed [31:0] dflt_angle_r, dflt_angle_nxt;
  logic signed [31:0] speed_r, speed_nxt;
  logic signed [31:0] time_r, time_nxt;
  logic signed [31:0] angle_r, angle_nxt;
  logic [1:0]         mode_r, mode_nxt;

  kind_t       kind;
  logic        frame_done, frame_ok;
  logic [7:0]  cmd, len;
  logic [31:0] word_a, word_b;
  logic        note, word_reply;
  logic [31:0] word;
  logic [7:0]  rep_len, rep_b4;

  // Configuration registers. The defaults are loaded together with the
  // targets at reset.
  always_comb begin
    dflt_speed_nxt = dflt_speed_r;
    dflt_angle_nxt = dflt_angle_r;
    if (!rst_n) begin
      dflt_speed_nxt = DEFAULT_SPEED_RST;
      dflt_angle_nxt = DEFAULT_ANGLE_RST;
    end else if (cfg_we && cfg_idx_t'(cfg_index) == CFG_DEFAULT_SPEED) begin
      dflt_speed_nxt = cfg_data;
    end else if (cfg_we && cfg_idx_t'(cfg_index) == CFG_DEFAULT_ANGLE) begin
      dflt_angle_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    dflt_speed_r <= dflt_speed_nxt;
    dflt_angle_r <= dflt_angle_nxt;
    if (!rst_n) begin
      for (int i = 0; i < NUM_CODES; i++) code_r[i] <= CODE_RST[i];
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CODE_SET_SPEED:   code_r[0] <= cfg_data[7:0];
        CFG_CODE_QUERY_SPEED: code_r[1] <= cfg_data[7:0];
        CFG_CODE_SPEED_TIME:  code_r[2] <= cfg_data[7:0];
        CFG_CODE_STOP:        code_r[3] <= cfg_data[7:0];
        CFG_CODE_SET_ANGLE:   code_r[4] <= cfg_data[7:0];
        CFG_CODE_QUERY_ANGLE: code_r[5] <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Receiver phase and body counter.
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    if (accept) begin
      case (phase_r)
        PH_HEAD1: begin
          phase_nxt = (rx_byte == HEAD1_BYTE) ? PH_BODY : PH_HEAD0;
          cnt_nxt   = '0;
        end
        PH_BODY: begin
          if (cnt_r == BODY_LAST) begin
            phase_nxt = PH_HEAD0;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        default: begin
          phase_nxt = (rx_byte == HEAD0_BYTE) ? PH_HEAD1 : PH_HEAD0;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

  // Frame check and command decode on the last body byte.
  assign cmd        = store_r[0];
  assign len        = store_r[1];
  assign word_a     = {store_r[5], store_r[4], store_r[3], store_r[2]};
  assign word_b     = {store_r[9], store_r[8], store_r[7], store_r[6]};
  assign frame_done = accept && phase_r == PH_BODY && cnt_r == BODY_LAST;
  assign frame_ok   = store_r[12] == TAIL0_BYTE && rx_byte == TAIL1_BYTE &&
                      sum_r == store_r[11];

  always_comb begin
    if      (cmd == code_r[0]) kind = K_SET_SPEED;
    else if (cmd == code_r[1]) kind = K_QUERY_SPEED;
    else if (cmd == code_r[2]) kind = K_SPEED_TIME;
    else if (cmd == code_r[3]) kind = K_STOP;
    else if (cmd == code_r[4]) kind = K_SET_ANGLE;
    else if (cmd == code_r[5]) kind = K_QUERY_ANGLE;
    else                       kind = K_NONE;
  end

  always_comb begin
    speed_nxt  = speed_r;
    time_nxt   = time_r;
    angle_nxt  = angle_r;
    mode_nxt   = mode_r;
    note       = 1'b0;
    word_reply = 1'b0;
    word       = '0;
    case (kind)
      K_SET_SPEED: begin
        if (len >= MIN_LEN_ONE) speed_nxt = word_a;
        mode_nxt = MODE_SPEED;
        note     = 1'b1;
      end
      K_QUERY_SPEED: begin
        word_reply = 1'b1;
        word       = speed_r;
      end
      K_SPEED_TIME: begin
        if (len >= MIN_LEN_TWO) begin
          speed_nxt = word_a;
          time_nxt  = word_b;
        end
        mode_nxt = MODE_TIMED;
        note     = 1'b1;
      end
      K_STOP: begin
        speed_nxt = '0;
        time_nxt  = '0;
        mode_nxt  = MODE_IDLE;
        note      = 1'b1;
      end
      K_SET_ANGLE: begin
        if (len >= MIN_LEN_ONE) angle_nxt = word_a;
      end
      K_QUERY_ANGLE: begin
        word_reply = 1'b1;
        word       = angle_r;
      end
      default: ;
    endcase
  end

  assign job_push = frame_done && frame_ok && kind != K_NONE;
  assign rep_len  = word_reply ? LEN_WORD : LEN_ACK;
  assign rep_b4   = word_reply ? word[7:0] : OK_CODE;

  always_comb begin
    job.cmd        = cmd;
    job.word_reply = word_reply;
    job.word       = word;
    job.csum       = HEAD_SUM + cmd + rep_len + rep_b4 + word[15:8] + word[23:16] +
                     word[31:24];
    job.notify     = note;
    job.speed      = speed_nxt;
    job.duration   = time_nxt;
    job.angle      = angle_nxt;
    job.mode       = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD0;
      cnt_r   <= '0;
      speed_r <= dflt_speed_nxt;
      time_r  <= '0;
      angle_r <= dflt_angle_nxt;
      mode_r  <= MODE_IDLE;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      if (job_push) begin
        speed_r <= speed_nxt;
        time_r  <= time_nxt;
        angle_r <= angle_nxt;
        mode_r  <= mode_nxt;
      end
    end
  end

  // Body bytes and the running checksum over body bytes 0 to 10.
  always_ff @(posedge clk) begin
    if (accept && phase_r == PH_HEAD1) sum_r <= HEAD_SUM;
    if (accept && phase_r == PH_BODY) begin
      store_r[cnt_r] <= rx_byte;
      if (cnt_r <= SUM_LAST) sum_r <= sum_r + rx_byte;
    end
  end

  a_push_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> (phase_r == PH_BODY && cnt_r == BODY_LAST))
    else $error("reply queued outside the last body byte");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !q_full)
    else $error("reply queued while the job queue is full");

  a_count_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (phase_r == PH_BODY))
    else $error("body counter running outside the body phase");

  a_idle_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (job_push && kind == K_STOP) |=> (mode_r == MODE_IDLE && speed_r == '0))
    else $error("stop did not clear the motion targets");

endmodule

[hdl/fucs_job_fifo.sv]
// Short queue of reply jobs between the receive front and transmit back.
// Depends on fucs_pkg for job_t and the queue depth.
module fucs_job_fifo import fucs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head
);

  job_t                q_r [JQ_DEPTH];
  logic [JQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [JQ_CNT_W-1:0] count_r;
  logic                do_push, do_pop;

  assign full    = count_r == JQ_CNT_W'(JQ_DEPTH);
  assign empty   = count_r == '0;
  assign head    = q_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_ptr_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == JQ_PTR_W'(JQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == JQ_PTR_W'(JQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + JQ_CNT_W'(do_push) - JQ_CNT_W'(do_pop);
    end
  end

endmodule

[hdl/fucs_tx_back.sv]
// Transmit side: walks the head job of the queue through its sixteen
// reply bytes. Depends on fucs_pkg.
module fucs_tx_back import fucs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  job_t               job,
  output logic               job_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [7:0]         tx_byte,
  output logic               last_byte,
  output logic               notify,
  output logic signed [31:0] speed_target,
  output logic signed [31:0] time_target,
  output logic signed [31:0] angle_target,
  output logic [1:0]         run_mode
);

  logic [3:0] idx_r;
  logic       take;

  assign out_empty = !job_valid;
  assign take      = out_pop && job_valid;
  assign last_byte = idx_r == TX_LAST;
  assign job_pop   = take && last_byte;

  always_comb begin
    case (idx_r)
      4'd0:    tx_byte = HEAD0_BYTE;
      4'd1:    tx_byte = HEAD1_BYTE;
      4'd2:    tx_byte = job.cmd;
      4'd3:    tx_byte = job.word_reply ? LEN_WORD : LEN_ACK;
      4'd4:    tx_byte = job.word_reply ? job.word[7:0] : OK_CODE;
      4'd5:    tx_byte = job.word[15:8];
      4'd6:    tx_byte = job.word[23:16];
      4'd7:    tx_byte = job.word[31:24];
      4'd13:   tx_byte = job.csum;
      4'd14:   tx_byte = TAIL0_BYTE;
      4'd15:   tx_byte = TAIL1_BYTE;
      default: tx_byte = 8'h00;
    endcase
  end

  assign notify       = job.notify;
  assign speed_target = job.speed;
  assign time_target  = job.duration;
  assign angle_target = job.angle;
  assign run_mode     = job.mode;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (take) begin
      idx_r <= last_byte ? '0 : idx_r + 1'b1;
    end
  end

endmodule

[hdl/framed_uart_command_slave.sv]
// Framed serial command slave: one received byte per transfer, sixteen reply bytes per frame.
// The reply job to a good frame is written into the job queue at its last byte's transfer.
// Throughput: one input byte per cycle unless in_full; one reply byte per cycle while popped; 2-deep job queue.
// Input stalls (in_full) only when two whole replies are still queued for the result side.
// Reset (rst_n, synchronous, active low) restarts head hunting, empties the queue and
// reloads codes, default targets and run mode; no clearing pass is needed.
module framed_uart_command_slave import fucs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // Received bytes, queue-style input.
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_rx_byte,
  // Reply bytes, queue-style output.
  output logic               out_empty,
  input  logic               out_pop,
  output logic [7:0]         out_tx_byte,
  output logic               out_last_byte,
  output logic               out_notify,
  output logic signed [31:0] out_speed_target,
  output logic signed [31:0] out_time_target,
  output logic signed [31:0] out_angle_target,
  output logic [1:0]         out_run_mode,
  // Configuration writes.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic in_accept;
  logic job_push, job_pop;
  logic q_full, q_empty;
  job_t job_in, job_head;

  // The front never needs to hold back a byte unless the job queue has no
  // room; a full queue stops every input transfer so a frame end can always
  // queue its reply.
  assign in_full   = q_full;
  assign in_accept = in_push && !in_full;

  // Configuration registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  // Front: hunts for the head, captures the body, checks tail and checksum,
  // decodes the command, updates the targets and queues the reply job.
  fucs_rx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .rx_byte   (in_rx_byte),
    .q_full    (q_full),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_push  (job_push),
    .job       (job_in)
  );

  // Queue between the two sides so each can stall on its own.
  fucs_job_fifo u_jobs (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (job_push),
    .wr_job (job_in),
    .pop    (job_pop),
    .full   (q_full),
    .empty  (q_empty),
    .head   (job_head)
  );

  // Back: serializes the oldest job one byte per output transfer and
  // releases it after the sixteenth byte.
  fucs_tx_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (!q_empty),
    .job          (job_head),
    .job_pop      (job_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .tx_byte      (out_tx_byte),
    .last_byte    (out_last_byte),
    .notify       (out_notify),
    .speed_target (out_speed_target),
    .time_target  (out_time_target),
    .angle_target (out_angle_target),
    .run_mode     (out_run_mode)
  );

endmodule

[tb/fucs_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for framed_uart_command_slave: follows the command codes and predicts every reply byte.
// It watches all three channels and compares each popped byte with the oldest prediction.
// Depends on fucs_pkg for the frame constants, run modes and register indexes.
module fucs_checker import fucs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [7:0]         in_rx_byte,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic [7:0]         out_tx_byte,
  input  logic               out_last_byte,
  input  logic               out_notify,
  input  logic signed [31:0] out_speed_target,
  input  logic signed [31:0] out_time_target,
  input  logic signed [31:0] out_angle_target,
  input  logic [1:0]         out_run_mode,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 mismatches,
  output int                 awaiting,
  output int                 frames_answered
);

  typedef enum logic [1:0] {HUNT_HEAD0, HUNT_HEAD1, IN_BODY} rx_phase_t;

  typedef struct packed {
    logic [7:0]         tx_byte;
    logic               last_byte;
    logic               notify;
    logic signed [31:0] speed;
    logic signed [31:0] duration;
    logic signed [31:0] angle;
    logic [1:0]         mode;
  } reply_beat_t;

  rx_phase_t          phase;
  logic [CNT_W-1:0]   body_cnt;
  logic [7:0]         body [BODY_LEN];
  logic [7:0]         cmd_code [NUM_CODES];
  logic signed [31:0] speed_now;
  logic signed [31:0] duration_now;
  logic signed [31:0] angle_now;
  logic signed [31:0] dflt_speed;
  logic signed [31:0] dflt_angle;
  logic [1:0]         mode_now;
  reply_beat_t        reply_q [$];

  task automatic reset_model();
    int k;
    phase    = HUNT_HEAD0;
    body_cnt = '0;
    for (k = 0; k < NUM_CODES; k++) cmd_code[k] = CODE_RST[k];
    dflt_speed      = DEFAULT_SPEED_RST;
    dflt_angle      = DEFAULT_ANGLE_RST;
    speed_now       = dflt_speed;
    angle_now       = dflt_angle;
    duration_now    = '0;
    mode_now        = MODE_IDLE;
    mismatches      = 0;
    frames_answered = 0;
    reply_q.delete();
  endtask

  // Builds the sixteen reply bytes, each tagged with the targets after the command.
  task automatic queue_reply(input logic [7:0] cmd, input logic [7:0] len,
                             input logic [31:0] word, input logic word_reply,
                             input logic note);
    logic [7:0]  f [16];
    logic [7:0]  sum;
    reply_beat_t beat;
    int          i;
    for (i = 0; i < 16; i++) f[i] = 8'h00;
    f[0] = HEAD0_BYTE;
    f[1] = HEAD1_BYTE;
    f[2] = cmd;
    f[3] = len;
    if (word_reply) begin
      f[4] = word[7:0];
      f[5] = word[15:8];
      f[6] = word[23:16];
      f[7] = word[31:24];
    end else begin
      f[4] = OK_CODE;
    end
    sum = 8'h00;
    for (i = 0; i < 13; i++) sum = sum + f[i];
    f[13] = sum;
    f[14] = TAIL0_BYTE;
    f[15] = TAIL1_BYTE;
    for (i = 0; i < 16; i++) begin
      beat.tx_byte   = f[i];
      beat.last_byte = (i == 15);
      beat.notify    = note;
      beat.speed     = speed_now;
      beat.duration  = duration_now;
      beat.angle     = angle_now;
      beat.mode      = mode_now;
      reply_q.push_back(beat);
    end
    frames_answered++;
  endtask

  // First matching code wins, in the fixed order of the register list.
  task automatic run_command();
    logic [7:0]  cmd;
    logic [7:0]  len;
    logic [31:0] word_lo;
    logic [31:0] word_hi;
    cmd     = body[0];
    len     = body[1];
    word_lo = {body[5], body[4], body[3], body[2]};
    word_hi = {body[9], body[8], body[7], body[6]};
    if (cmd == cmd_code[CFG_CODE_SET_SPEED]) begin
      if (len >= MIN_LEN_ONE) speed_now = word_lo;
      mode_now = MODE_SPEED;
      queue_reply(cmd, LEN_ACK, '0, 1'b0, 1'b1);
    end else if (cmd == cmd_code[CFG_CODE_QUERY_SPEED]) begin
      queue_reply(cmd, LEN_WORD, speed_now, 1'b1, 1'b0);
    end else if (cmd == cmd_code[CFG_CODE_SPEED_TIME]) begin
      if (len >= MIN_LEN_TWO) begin
        speed_now    = word_lo;
        duration_now = word_hi;
      end
      mode_now = MODE_TIMED;
      queue_reply(cmd, LEN_ACK, '0, 1'b0, 1'b1);
    end else if (cmd == cmd_code[CFG_CODE_STOP]) begin
      speed_now    = '0;
      duration_now = '0;
      mode_now     = MODE_IDLE;
      queue_reply(cmd, LEN_ACK, '0, 1'b0, 1'b1);
    end else if (cmd == cmd_code[CFG_CODE_SET_ANGLE]) begin
      if (len >= MIN_LEN_ONE) angle_now = word_lo;
      queue_reply(cmd, LEN_ACK, '0, 1'b0, 1'b0);
    end else if (cmd == cmd_code[CFG_CODE_QUERY_ANGLE]) begin
      queue_reply(cmd, LEN_WORD, angle_now, 1'b1, 1'b0);
    end
  endtask

  task automatic absorb_rx_byte(input logic [7:0] b);
    logic [7:0] sum;
    int         i;
    case (phase)
      HUNT_HEAD1: begin
        // A wrong second head byte drops both; it is not taken as a new head.
        phase    = (b == HEAD1_BYTE) ? IN_BODY : HUNT_HEAD0;
        body_cnt = '0;
      end
      IN_BODY: begin
        body[body_cnt] = b;
        if (body_cnt == BODY_LAST) begin
          phase    = HUNT_HEAD0;
          body_cnt = '0;
          sum      = HEAD_SUM;
          for (i = 0; i < 11; i++) sum = sum + body[i];
          if (body[12] == TAIL0_BYTE && body[13] == TAIL1_BYTE && sum == body[11])
            run_command();
        end else begin
          body_cnt = body_cnt + 1'b1;
        end
      end
      default: begin
        phase    = (b == HEAD0_BYTE) ? HUNT_HEAD1 : HUNT_HEAD0;
        body_cnt = '0;
      end
    endcase
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
  endtask

  task automatic check_beat(input reply_beat_t want);
    if (out_tx_byte !== want.tx_byte)
      note_mismatch("tx_byte", 32'(out_tx_byte), 32'(want.tx_byte));
    if (out_last_byte !== want.last_byte)
      note_mismatch("last_byte", 32'(out_last_byte), 32'(want.last_byte));
    if (out_notify !== want.notify)
      note_mismatch("notify", 32'(out_notify), 32'(want.notify));
    if (out_speed_target !== want.speed)
      note_mismatch("speed_target", out_speed_target, want.speed);
    if (out_time_target !== want.duration)
      note_mismatch("time_target", out_time_target, want.duration);
    if (out_angle_target !== want.angle)
      note_mismatch("angle_target", out_angle_target, want.angle);
    if (out_run_mode !== want.mode)
      note_mismatch("run_mode", 32'(out_run_mode), 32'(want.mode));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          // The defaults only load at a reset, and reset is not repeated in a run.
          CFG_DEFAULT_SPEED: dflt_speed = cfg_data;
          CFG_DEFAULT_ANGLE: dflt_angle = cfg_data;
          default:           cmd_code[cfg_index] = cfg_data[7:0];
        endcase
      end
      // Pop before absorbing: a byte taken at this edge cannot answer yet.
      if (out_pop && !out_empty) begin
        if (reply_q.size() == 0)
          note_mismatch("reply byte with none pending", 32'(out_tx_byte), '0);
        else check_beat(reply_q.pop_front());
      end
      if (in_push && !in_full) absorb_rx_byte(in_rx_byte);
    end
    awaiting = reply_q.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Top of the framed_uart_command_slave testbench: clock, reset, byte stimulus and verdict.
// Instantiates the block and fucs_checker; depends on fucs_pkg for constants and indexes.
module tb_top;
  import fucs_pkg::*;

  // Cycles to let pass after the last reply before a register write; the block queues its reply
  // job at the closing byte's transfer, so this is generous.
  localparam int SETTLE_CYCLES   = 4;
  localparam int END_CYCLES      = 20;
  // Long receiver hold-off; enough for two replies to queue up and stall the input.
  localparam int HOLDOFF_CYCLES  = 300;
  // Longest legal stretch without any transfer is the hold-off; allow it many times over.
  localparam int WATCHDOG_LIMIT  = 3000;

  typedef enum {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_TAIL0, FRAME_BAD_TAIL1} frame_flaw_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic [7:0]         out_tx_byte;
  logic               out_last_byte;
  logic               out_notify;
  logic signed [31:0] out_speed_target;
  logic signed [31:0] out_time_target;
  logic signed [31:0] out_angle_target;
  logic [1:0]         out_run_mode;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = 3'd0;
  logic [31:0]        cfg_data = 32'd0;

  int mismatches;
  int awaiting;
  int frames_answered;

  int   push_idle_pct = 0;
  int   pop_idle_pct = 0;
  logic holdoff_req = 1'b0;
  int   bytes_sent = 0;
  int   frames_offered = 0;
  int   quiet_cycles = 0;

  logic [7:0] cur_codes [NUM_CODES];
  logic [7:0] next_codes [NUM_CODES];

  always #4 clk = ~clk;

  framed_uart_command_slave u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_rx_byte       (in_rx_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_tx_byte      (out_tx_byte),
    .out_last_byte    (out_last_byte),
    .out_notify       (out_notify),
    .out_speed_target (out_speed_target),
    .out_time_target  (out_time_target),
    .out_angle_target (out_angle_target),
    .out_run_mode     (out_run_mode),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  fucs_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_rx_byte       (in_rx_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_tx_byte      (out_tx_byte),
    .out_last_byte    (out_last_byte),
    .out_notify       (out_notify),
    .out_speed_target (out_speed_target),
    .out_time_target  (out_time_target),
    .out_angle_target (out_angle_target),
    .out_run_mode     (out_run_mode),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .awaiting         (awaiting),
    .frames_answered  (frames_answered)
  );

  // Receiver: pops at random, or holds off for a long stretch when asked. The hold-off is
  // counted here so that the sender keeps offering bytes meanwhile.
  initial begin
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        out_pop <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holdoff_req = 1'b0;
      end else begin
        out_pop <= rst_n && ($urandom_range(0, 99) >= pop_idle_pct);
      end
    end
  end

  // Watchdog: a run that stops making transfers for too long has hung.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offers one byte, with random idle cycles first, and returns after its transfer.
  // push is left high so that back-to-back bytes need no second assignment in a step.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < push_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push    <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_full);
    bytes_sent++;
  endtask

  // Sends a whole frame. The payload holds the eight data bytes and the spare byte,
  // least significant first; the checksum covers bytes 0 to 12 unless flawed on purpose.
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                            input logic [71:0] payload, input frame_flaw_t flaw);
    logic [7:0] f [16];
    logic [7:0] sum;
    int         i;
    f[0] = HEAD0_BYTE;
    f[1] = HEAD1_BYTE;
    f[2] = cmd;
    f[3] = len;
    for (i = 0; i < 9; i++) f[4 + i] = payload[8 * i +: 8];
    sum = 8'h00;
    for (i = 0; i < 13; i++) sum = sum + f[i];
    f[13] = sum;
    f[14] = TAIL0_BYTE;
    f[15] = TAIL1_BYTE;
    case (flaw)
      FRAME_BAD_SUM:   f[13] = f[13] ^ (8'd1 << $urandom_range(0, 7));
      FRAME_BAD_TAIL0: f[14] = f[14] ^ 8'($urandom_range(1, 255));
      FRAME_BAD_TAIL1: f[15] = f[15] ^ 8'($urandom_range(1, 255));
      default: ;
    endcase
    for (i = 0; i < 16; i++) send_byte(f[i]);
    frames_offered++;
  endtask

  // Mostly well-formed frames with random content, the rest broken frames and noise.
  task automatic send_random_sequence();
    int          pick;
    int          i;
    logic [7:0]  cmd;
    logic [7:0]  len;
    logic [7:0]  b;
    logic [71:0] payload;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 85) cmd = cur_codes[$urandom_range(0, NUM_CODES - 1)];
    else cmd = 8'($urandom);
    // Lengths cluster around the two storage thresholds.
    case ($urandom_range(0, 9))
      0:       len = 8'($urandom_range(0, 3));
      1:       len = 8'($urandom_range(4, 7));
      2:       len = MIN_LEN_TWO;
      3:       len = 8'hFF;
      default: len = 8'($urandom);
    endcase
    for (i = 0; i < 9; i++) payload[8 * i +: 8] = rand_byte();
    if (pick < 78) begin
      send_frame(cmd, len, payload, FRAME_GOOD);
    end else if (pick < 84) begin
      send_frame(cmd, len, payload, FRAME_BAD_SUM);
    end else if (pick < 87) begin
      send_frame(cmd, len, payload, FRAME_BAD_TAIL0);
    end else if (pick < 90) begin
      send_frame(cmd, len, payload, FRAME_BAD_TAIL1);
    end else if (pick < 95) begin
      // Head byte followed by a wrong second byte, then a real frame.
      send_byte(HEAD0_BYTE);
      b = 8'($urandom);
      if (b == HEAD1_BYTE) b = HEAD0_BYTE;
      send_byte(b);
      send_frame(cmd, len, payload, FRAME_GOOD);
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(rand_byte());
    end
  endtask

  task automatic run_random(input int count, input int holdoff_at);
    int n;
    for (n = 0; n < count; n++) begin
      if (n == holdoff_at) holdoff_req = 1'b1;
      send_random_sequence();
    end
  endtask

  // Stops offering bytes and waits until every predicted reply byte has been popped.
  // The count is read at the falling edge, after the checker has seen the rising one.
  task automatic wait_for_replies(input int settle);
    in_push <= 1'b0;
    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Writes all eight registers back to back; only called with the block idle.
  task automatic load_codes(input logic [31:0] dflt_speed, input logic [31:0] dflt_angle);
    logic [31:0] vals [8];
    int          k;
    for (k = 0; k < NUM_CODES; k++) vals[k] = {24'd0, next_codes[k]};
    vals[CFG_DEFAULT_SPEED] = dflt_speed;
    vals[CFG_DEFAULT_ANGLE] = dflt_angle;
    for (k = 0; k < 8; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(k);
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    for (k = 0; k < NUM_CODES; k++) cur_codes[k] = next_codes[k];
  endtask

  initial begin
    int k;
    for (k = 0; k < NUM_CODES; k++) cur_codes[k] = CODE_RST[k];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First setting: the reset codes, written explicitly, and extreme defaults that
    // must not disturb the live targets. Sender idles lightly, receiver heavily.
    push_idle_pct = 16;
    pop_idle_pct  = 62;
    for (k = 0; k < NUM_CODES; k++) next_codes[k] = CODE_RST[k];
    load_codes(32'h7FFF_FFFF, 32'h8000_0000);

    // Directed frames: each command, payload extremes, short lengths, bad frames.
    send_frame(cur_codes[CFG_CODE_SET_SPEED], MIN_LEN_ONE, 72'h00_00000000_7FFFFFFF,
               FRAME_GOOD);
    send_frame(cur_codes[CFG_CODE_QUERY_SPEED], 8'h00, 72'h0, FRAME_GOOD);
    send_frame(cur_codes[CFG_CODE_SPEED_TIME], MIN_LEN_TWO, 72'h5A_FFFFFFFF_80000000,
               FRAME_GOOD);
    send_frame(cur_codes[CFG_CODE_QUERY_SPEED], 8'hFF, 72'hFF_FFFFFFFF_FFFFFFFF,
               FRAME_GOOD);
    send_frame(cur_codes[CFG_CODE_SET_ANGLE], 8'hFF, 72'hFF_FFFFFFFF_FFFFFFFF, FRAME_GOOD);
    send_frame(cur_codes[CFG_CODE_QUERY_ANGLE], 8'h04, 72'h0, FRAME_GOOD);
    send_frame(cur_codes[CFG_CODE_STOP], 8'h00, 72'h0, FRAME_GOOD);
    send_frame(cur_codes[CFG_CODE_QUERY_SPEED], 8'h04, 72'h0, FRAME_GOOD);
    // Lengths below the thresholds: speed commands still change the mode, payload is not stored.
    send_frame(cur_codes[CFG_CODE_SET_SPEED], 8'h03, 72'h00_00000000_12345678, FRAME_GOOD);
    send_frame(cur_codes[CFG_CODE_SPEED_TIME], 8'h07, 72'hA5_C3C3C3C3_3C3C3C3C,
               FRAME_GOOD);
    send_frame(cur_codes[CFG_CODE_SET_ANGLE], 8'h00, 72'h55_55555555_55555555, FRAME_GOOD);
    send_frame(cur_codes[CFG_CODE_QUERY_ANGLE], 8'h00, 72'h0, FRAME_GOOD);
    // An unknown command answers nothing.
    send_frame(8'h77, 8'h08, 72'h11_22334455_66778899, FRAME_GOOD);
    // Broken frames are dropped silently.
    send_frame(cur_codes[CFG_CODE_SET_SPEED], 8'h04, 72'h0, FRAME_BAD_SUM);
    send_frame(cur_codes[CFG_CODE_SET_SPEED], 8'h04, 72'h0, FRAME_BAD_TAIL0);
    send_frame(cur_codes[CFG_CODE_SET_SPEED], 8'h04, 72'h0, FRAME_BAD_TAIL1);
    // Wrong second head byte, and a repeated first head byte, each before a frame.
    send_byte(HEAD0_BYTE);
    send_byte(8'h00);
    send_frame(cur_codes[CFG_CODE_QUERY_SPEED], 8'h00, 72'h0, FRAME_GOOD);
    send_byte(HEAD0_BYTE);
    send_byte(HEAD0_BYTE);
    send_frame(cur_codes[CFG_CODE_SPEED_TIME], 8'hFF, 72'h00_00000000_00000000,
               FRAME_GOOD);
    // Stray bytes between frames, including tail and head values.
    send_byte(8'hFF);
    send_byte(HEAD1_BYTE);
    send_byte(TAIL0_BYTE);
    send_byte(TAIL1_BYTE);
    send_frame(cur_codes[CFG_CODE_QUERY_SPEED], 8'h00, 72'h0, FRAME_GOOD);

    // Random frames; the receiver holds off as they start so the block fills up.
    run_random(3, 0);
    wait_for_replies(SETTLE_CYCLES);

    // Second setting: extreme code values, some equal to frame marker bytes.
    // The idling is swapped: sender idles heavily, receiver lightly.
    push_idle_pct = 62;
    pop_idle_pct  = 16;
    next_codes[CFG_CODE_SET_SPEED]   = 8'h00;
    next_codes[CFG_CODE_QUERY_SPEED] = 8'hFF;
    next_codes[CFG_CODE_SPEED_TIME]  = HEAD0_BYTE;
    next_codes[CFG_CODE_STOP]        = HEAD1_BYTE;
    next_codes[CFG_CODE_SET_ANGLE]   = TAIL0_BYTE;
    next_codes[CFG_CODE_QUERY_ANGLE] = TAIL1_BYTE;
    load_codes(32'h0000_0000, 32'hFFFF_FFFF);
    for (k = 0; k < NUM_CODES; k++)
      send_frame(cur_codes[k], 8'hFF, {8'($urandom), $urandom, $urandom}, FRAME_GOOD);
    run_random(1, -1);
    wait_for_replies(SETTLE_CYCLES);

    // Third setting: codes drawn from a narrow range so that several are equal and the
    // first match in the fixed order has to win. No idling from here on.
    push_idle_pct = 0;
    pop_idle_pct  = 0;
    for (k = 0; k < NUM_CODES; k++) next_codes[k] = 8'($urandom_range(0, 7));
    load_codes($urandom, $urandom);
    run_random(2, -1);
    wait_for_replies(SETTLE_CYCLES);

    // Last setting: back to the reset codes, with a second long hold-off.
    for (k = 0; k < NUM_CODES; k++) next_codes[k] = CODE_RST[k];
    load_codes($urandom, $urandom);
    run_random(2, 0);

    wait_for_replies(END_CYCLES);
    $display("Run covered %0d received bytes in %0d offered frames and %0d checked replies,",
             bytes_sent, frames_offered, frames_answered);
    $display("over four code settings with idling, back-pressure and drain pauses.");
    if (mismatches == 0 && awaiting == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
